>>> sv/rgb_median_filter_3x3_unit_defines.svh
// Assertion macros for the RGB 3x3 median filter.
// Used by the port checker; needs clk and rst_n in the enclosing scope.
`ifndef RGB_MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH
`define RGB_MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH

// Check with reset masking.
`define RMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that also covers the reset cycles.
`define RMF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rmf_pkg.sv
// Shared types, constants and compare helpers for the RGB 3x3 median filter.
// No dependencies.
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int CFG_W       = 11;
  localparam int CROW_W      = 12;
  localparam int CCOL_W      = 10;
  localparam int WIDTH_RESET = 640;
  localparam int MIN_WIDTH   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  typedef struct packed {
    logic  frame_start;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } in_word_t;

  typedef struct packed {
    logic [CROW_W-1:0] centre_row;
    logic [CCOL_W-1:0] centre_col;
    chan_t             red_median;
    chan_t             green_median;
    chan_t             blue_median;
  } out_word_t;

  typedef struct packed {
    logic [CROW_W-1:0] centre_row;
    logic [CCOL_W-1:0] centre_col;
    pixel_t [8:0]      pix;
  } win_word_t;

  typedef struct packed {
    chan_t lo;
    chan_t mi;
    chan_t hi;
  } trio_t;

  typedef trio_t [2:0] ch_rows_t;

  function automatic chan_t chan_of(input pixel_t p, input int k);
    chan_t res;
    case (k)
      0:       res = p.blue;
      1:       res = p.green;
      default: res = p.red;
    endcase
    return res;
  endfunction

  function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
    chan_t x;
    chan_t y;
    chan_t z;
    chan_t t;
    trio_t res;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    res.lo = x;
    res.mi = y;
    res.hi = z;
    return res;
  endfunction

  function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
    chan_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    chan_t lo;
    chan_t hi;
    chan_t m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

>>> sv/rgb_median_filter_3x3_unit.sv
// Top level of the streaming RGB 3x3 median filter.
// Depends on rmf_pkg, rmf_front, rmf_fifo and rmf_back.
//
// Usage:
//   Input queue: drive in_data and raise in_push; a word is taken at an edge with
//   in_push high and in_full low. Pixels come in raster order; frame_start marks
//   the first pixel of an image. Each pixel at row>=2, col>=2 yields one word
//   for the centre one row up and one column left; border pixels yield nothing.
//   Result queue: while out_empty is low the oldest word is on out_data; raise
//   out_pop to take it.
//   Config: cfg_we with cfg_wdata sets the line width (clamped to 3..MAX_WIDTH);
//   write only while the block holds no words in flight.
//   Throughput is one pixel per cycle while in_full is low; a result follows the
//   pixel that releases it through line store read, window update, two median stages.
//   Reset clears counters and window and sets the width to 640; line stores
//   hold no data until a row has passed. When the receiver stalls, the 4-deep
//   result queue and the 4-deep window queue fill, then in_full rises.
`timescale 1ns / 1ps

module rgb_median_filter_3x3_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rmf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_push,
  output logic                       in_full,
  input  rmf_pkg::in_word_t          in_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output rmf_pkg::out_word_t         out_data
);

  logic                        q_push;
  logic                        q_pop;
  logic                        q_empty;
  logic [rmf_pkg::QCNT_W-1:0]  q_count;
  rmf_pkg::win_word_t          q_wdata;
  rmf_pkg::win_word_t          q_rdata;

  rmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_count   (q_count)
  );

  rmf_fifo #(
    .W     ($bits(rmf_pkg::win_word_t)),
    .DEPTH (rmf_pkg::QUEUE_DEPTH)
  ) u_win_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  rmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> sv/rmf_fifo.sv
// Small register FIFO with occupancy count.
// Used for the window queue and the result queue; no package dependency.
`timescale 1ns / 1ps

module rmf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> sv/rmf_front.sv
// Front end: width register, row/column tracking, line stores and 3x3 window.
// Depends on rmf_pkg; pushes one window word per interior pixel.
`timescale 1ns / 1ps

module rmf_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rmf_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_push,
  output logic                        in_full,
  input  rmf_pkg::in_word_t           in_data,
  output logic                        q_push,
  output rmf_pkg::win_word_t          q_data,
  input  logic [rmf_pkg::QCNT_W-1:0]  q_count
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int LWE     = (rmf_pkg::CFG_W > COL_W + 1) ? rmf_pkg::CFG_W : COL_W + 1;
  localparam int RESET_W = (rmf_pkg::WIDTH_RESET < MAX_WIDTH) ? rmf_pkg::WIDTH_RESET
                                                               : MAX_WIDTH;
  localparam logic [COL_W-1:0] LAST_RESET = COL_W'(RESET_W - 1);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(MAX_ROWS - 1);
  localparam int QW = rmf_pkg::QCNT_W;

  logic [COL_W-1:0]         last_col_r, last_col_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic                     v1_r;
  logic                     fwd_r, fwd_nxt;
  logic                     emit1_r;
  logic [ROW_W-1:0]         r1_r;
  logic [COL_W-1:0]         c1_r;
  rmf_pkg::pixel_t          pix1_r, pix_cur;
  rmf_pkg::line_pair_t      rd_r, fwd_data_r, rd_eff, wr_pair;
  rmf_pkg::line_pair_t      mem_r [0:MAX_WIDTH-1];
  rmf_pkg::pixel_t [8:0]    win_r, win_nxt;
  logic [LWE-1:0]           wv;
  logic [QW:0]              occ;
  logic                     acc;
  logic [COL_W-1:0]         c_base, c_cur;
  logic [ROW_W-1:0]         r_cur;
  logic                     emit_cur;

  assign occ     = {1'b0, q_count} + {{QW{1'b0}}, v1_r};
  assign in_full = (occ >= (QW+1)'(rmf_pkg::QUEUE_DEPTH));
  assign acc     = in_push && !in_full;

  assign pix_cur = '{red: in_data.red_in, green: in_data.green_in, blue: in_data.blue_in};

  // clamp the written width to the supported range
  always_comb begin
    wv = LWE'(cfg_wdata);
    if (wv < LWE'(rmf_pkg::MIN_WIDTH)) begin
      wv = LWE'(rmf_pkg::MIN_WIDTH);
    end
    if (wv > LWE'(MAX_WIDTH)) begin
      wv = LWE'(MAX_WIDTH);
    end
    last_col_nxt = cfg_we ? COL_W'(wv - 1'b1) : last_col_r;
  end

  always_comb begin
    c_base   = in_data.frame_start ? '0 : col_r;
    r_cur    = in_data.frame_start ? '0 : row_r;
    c_cur    = (c_base > last_col_r) ? last_col_r : c_base;
    emit_cur = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (acc) begin
      if (c_cur == last_col_r) begin
        col_nxt = '0;
        row_nxt = (r_cur < ROW_LAST) ? r_cur + 1'b1 : r_cur;
      end else begin
        col_nxt = c_cur + 1'b1;
        row_nxt = r_cur;
      end
    end
    fwd_nxt = acc && v1_r && (c_cur == c1_r);
  end

  // bypass the line-store write still in flight to the same column
  always_comb begin
    rd_eff         = fwd_r ? fwd_data_r : rd_r;
    wr_pair.upper  = rd_eff.middle;
    wr_pair.middle = pix1_r;
  end

  always_comb begin
    win_nxt = win_r;
    if (v1_r) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = rd_eff.upper;
      win_nxt[3] = win_r[4];
      win_nxt[4] = win_r[5];
      win_nxt[5] = rd_eff.middle;
      win_nxt[6] = win_r[7];
      win_nxt[7] = win_r[8];
      win_nxt[8] = pix1_r;
    end
  end

  assign q_push            = v1_r && emit1_r;
  assign q_data.centre_row = rmf_pkg::CROW_W'(r1_r - ROW_W'(1));
  assign q_data.centre_col = rmf_pkg::CCOL_W'(c1_r - COL_W'(1));
  assign q_data.pix        = win_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= LAST_RESET;
      col_r      <= '0;
      row_r      <= '0;
      v1_r       <= 1'b0;
      fwd_r      <= 1'b0;
      win_r      <= '0;
    end else begin
      last_col_r <= last_col_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      v1_r       <= acc;
      fwd_r      <= fwd_nxt;
      win_r      <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r     <= pix_cur;
    r1_r       <= r_cur;
    c1_r       <= c_cur;
    emit1_r    <= emit_cur;
    fwd_data_r <= wr_pair;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= mem_r[c_cur];
    end
    if (v1_r) begin
      mem_r[c1_r] <= wr_pair;
    end
  end

endmodule

>>> sv/rmf_back.sv
// Back end: pipelined 3x3 median network per channel and result queue.
// Depends on rmf_pkg and rmf_fifo.
`timescale 1ns / 1ps

module rmf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rmf_pkg::win_word_t  q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output rmf_pkg::out_word_t  out_data
);

  localparam int OW = rmf_pkg::OCNT_W;

  logic [OW-1:0]                  o_count;
  logic [OW:0]                    occ;
  logic                           v1_r, v2_r;
  rmf_pkg::ch_rows_t [2:0]        rows_nxt, s1_rows_r;
  rmf_pkg::trio_t [2:0]           mid_nxt, s2_r;
  logic [rmf_pkg::CROW_W-1:0]     s1_row_r, s2_row_r;
  logic [rmf_pkg::CCOL_W-1:0]     s1_col_r, s2_col_r;
  rmf_pkg::out_word_t             res;

  assign occ   = {1'b0, o_count} + {{OW{1'b0}}, v1_r} + {{OW{1'b0}}, v2_r};
  assign q_pop = !q_empty && (occ < (OW+1)'(rmf_pkg::OUT_DEPTH));

  // sort each window row
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        rows_nxt[k][j] = rmf_pkg::sort3(rmf_pkg::chan_of(q_data.pix[3*j], k),
                                        rmf_pkg::chan_of(q_data.pix[3*j+1], k),
                                        rmf_pkg::chan_of(q_data.pix[3*j+2], k));
      end
    end
  end

  // max of lows, median of middles, min of highs
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mid_nxt[k].lo = rmf_pkg::max3(s1_rows_r[k][0].lo, s1_rows_r[k][1].lo,
                                    s1_rows_r[k][2].lo);
      mid_nxt[k].mi = rmf_pkg::med3(s1_rows_r[k][0].mi, s1_rows_r[k][1].mi,
                                    s1_rows_r[k][2].mi);
      mid_nxt[k].hi = rmf_pkg::min3(s1_rows_r[k][0].hi, s1_rows_r[k][1].hi,
                                    s1_rows_r[k][2].hi);
    end
  end

  always_comb begin
    res.centre_row   = s2_row_r;
    res.centre_col   = s2_col_r;
    res.red_median   = rmf_pkg::med3(s2_r[2].lo, s2_r[2].mi, s2_r[2].hi);
    res.green_median = rmf_pkg::med3(s2_r[1].lo, s2_r[1].mi, s2_r[1].hi);
    res.blue_median  = rmf_pkg::med3(s2_r[0].lo, s2_r[0].mi, s2_r[0].hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= q_pop;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_rows_r <= rows_nxt;
    s1_row_r  <= q_data.centre_row;
    s1_col_r  <= q_data.centre_col;
    s2_r      <= mid_nxt;
    s2_row_r  <= s1_row_r;
    s2_col_r  <= s1_col_r;
  end

  rmf_fifo #(
    .W     ($bits(rmf_pkg::out_word_t)),
    .DEPTH (rmf_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v2_r),
    .wdata (res),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty),
    .count (o_count)
  );

endmodule

>>> sv/rmf_checker.sv
// Port-level checks for the RGB 3x3 median filter, bound to the top level.
// Depends on rmf_pkg and rgb_median_filter_3x3_unit_defines.svh.
`timescale 1ns / 1ps
`include "rgb_median_filter_3x3_unit_defines.svh"

module rmf_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  logic                out_empty,
  input  logic                out_pop,
  input  rmf_pkg::out_word_t  out_data
);

  `RMF_ASSERT_RST(a_rst_empty, !rst_n |=> out_empty, "result queue not empty after reset")
  `RMF_ASSERT_RST(a_rst_ready, !rst_n |=> !in_full, "input full after reset")
  `RMF_ASSERT(a_full_needs_push, !in_full && !in_push |=> !in_full, "full without new word")
  `RMF_ASSERT(a_head_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_data), "head lost")

endmodule

bind rgb_median_filter_3x3_unit rmf_checker u_rmf_checker (.*);

>>> sim/rgb_median_filter_3x3_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_median_filter_3x3_unit: a clocked driver feeds pixel words
// and line-width writes from a script queue, a clocked monitor pops median words and
// checks them against an in-bench 3x3 median model. Depends on rmf_pkg and the unit.

module rgb_median_filter_3x3_unit_tb;
  import rmf_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_ROWS      = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int SHOW_LIMIT    = 10;

  typedef enum logic [1:0] {ACT_PIXEL, ACT_WIDTH, ACT_DRAIN, ACT_PACE} act_kind_e;
  typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} chan_sel_e;
  typedef enum logic [1:0] {STYLE_FULL, STYLE_NARROW, STYLE_EXTREME} pix_style_e;

  typedef struct packed {
    act_kind_e        kind;
    in_word_t         word;
    logic [CFG_W-1:0] width;
    int               push_idle;
    int               pop_stall;
  } act_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_push   = 1'b0;
  logic             in_full;
  in_word_t         in_data   = '0;
  logic             out_empty;
  logic             out_pop   = 1'b0;
  out_word_t        out_data;

  // filter model state
  pixel_t           upper_line  [MAX_WIDTH];
  pixel_t           middle_line [MAX_WIDTH];
  pixel_t           win [9];
  int               col_cnt;
  int               row_cnt;
  logic [CFG_W-1:0] line_width_q;

  act_t      script[$];
  out_word_t medians_due[$];
  int        push_idle_pct = 0;
  int        pop_stall_pct = 0;
  int        mismatches    = 0;
  int        calm          = 0;
  int        idle_cycles   = 0;
  act_t      drv_act;
  logic      drv_push;
  logic      drv_we;
  out_word_t want;

  rgb_median_filter_3x3_unit #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic chan_t window_median(input chan_sel_e sel);
    chan_t v [9];
    chan_t res;
    int i;
    int j;
    int below;
    int same;
    res = '0;
    for (i = 0; i < 9; i++) begin
      case (sel)
        SEL_RED:   v[i] = win[i].red;
        SEL_GREEN: v[i] = win[i].green;
        default:   v[i] = win[i].blue;
      endcase
    end
    // pick the value whose rank range covers the fifth position
    for (i = 0; i < 9; i++) begin
      below = 0;
      same  = 0;
      for (j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        else if (v[j] == v[i]) same++;
      end
      if (below <= 4 && below + same > 4) res = v[i];
    end
    return res;
  endfunction

  task automatic advance_filter(input in_word_t w);
    int eff;
    int r;
    int c;
    pixel_t pix;
    pixel_t up;
    pixel_t mid;
    out_word_t res;
    if (line_width_q < MIN_WIDTH) eff = MIN_WIDTH;
    else if (line_width_q > MAX_WIDTH) eff = MAX_WIDTH;
    else eff = line_width_q;
    if (w.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= eff) col_cnt = eff - 1;
    r = row_cnt;
    c = col_cnt;
    pix = {w.red_in, w.green_in, w.blue_in};
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = pix;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = up;
    win[3] = win[4];
    win[4] = win[5];
    win[5] = mid;
    win[6] = win[7];
    win[7] = win[8];
    win[8] = pix;
    if (r >= 2 && c >= 2) begin
      res.centre_row   = CROW_W'(r - 1);
      res.centre_col   = CCOL_W'(c - 1);
      res.red_median   = window_median(SEL_RED);
      res.green_median = window_median(SEL_GREEN);
      res.blue_median  = window_median(SEL_BLUE);
      medians_due.insert(medians_due.size(), res);
    end
    if (c + 1 >= eff) begin
      col_cnt = 0;
      if (row_cnt < MAX_ROWS - 1) row_cnt++;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  function automatic chan_t pick_chan(input pix_style_e style);
    chan_t v;
    case (style)
      STYLE_NARROW:  v = chan_t'(126 + $urandom_range(3));
      STYLE_EXTREME: v = $urandom_range(1) ? 8'hFF : 8'h00;
      default:       v = chan_t'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic add_pixel(input logic fs, input chan_t r, input chan_t g, input chan_t b);
    act_t a;
    a = '0;
    a.kind = ACT_PIXEL;
    a.word.frame_start = fs;
    a.word.red_in   = r;
    a.word.green_in = g;
    a.word.blue_in  = b;
    script.insert(script.size(), a);
  endtask

  task automatic add_control(input act_kind_e kind, input int width, input int idle,
                             input int stall);
    act_t a;
    a = '0;
    a.kind      = kind;
    a.width     = CFG_W'(width);
    a.push_idle = idle;
    a.pop_stall = stall;
    script.insert(script.size(), a);
  endtask

  task automatic add_frame(input int rows, input int cols, input pix_style_e style,
                           input bit noisy);
    int total;
    int k;
    total = rows * cols;
    if (noisy && $urandom_range(3) == 0) total = total - $urandom_range(cols - 1);
    for (k = 0; k < total; k++)
      add_pixel(k == 0 || (noisy && $urandom_range(149) == 0),
                pick_chan(style), pick_chan(style), pick_chan(style));
  endtask

  task automatic add_phase(input int idle, input int stall, input int width, input int eff,
                           input int count, input bit drain_inside);
    int sent;
    int rows;
    int pick;
    pix_style_e style;
    add_control(ACT_PACE, 0, idle, stall);
    add_control(ACT_WIDTH, width, 0, 0);
    sent = 0;
    while (sent < count) begin
      rows = $urandom_range(7, 3);
      pick = $urandom_range(9);
      style = (pick < 6) ? STYLE_FULL : (pick < 8) ? STYLE_NARROW : STYLE_EXTREME;
      add_frame(rows, eff, style, $urandom_range(3) == 0);
      sent += rows * eff;
      if (drain_inside && sent < count && $urandom_range(2) == 0) begin
        add_control(ACT_DRAIN, 0, 0, 0);
        drain_inside = 1'b0;
      end
    end
  endtask

  // driver: push pixel words, write the width once the pipe is quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      cfg_we  <= 1'b0;
    end else begin
      if (in_push && !in_full) advance_filter(in_data);
      drv_push = in_push && in_full;
      drv_we   = 1'b0;
      if (!drv_push && script.size() > 0) begin
        drv_act = script[0];
        case (drv_act.kind)
          ACT_PIXEL: begin
            if ($urandom_range(99) >= push_idle_pct) begin
              drv_push = 1'b1;
              in_data <= drv_act.word;
              void'(script.pop_front());
            end
          end
          ACT_PACE: begin
            push_idle_pct = drv_act.push_idle;
            pop_stall_pct = drv_act.pop_stall;
            void'(script.pop_front());
          end
          default: begin
            if (medians_due.size() == 0 && !in_push) calm++;
            else calm = 0;
            if (calm >= SETTLE_CYCLES) begin
              calm = 0;
              if (drv_act.kind == ACT_WIDTH) begin
                drv_we = 1'b1;
                cfg_wdata <= drv_act.width;
                line_width_q = drv_act.width;
              end
              void'(script.pop_front());
            end
          end
        endcase
      end
      in_push <= drv_push;
      cfg_we  <= drv_we;
    end
  end

  // monitor: pop median words and compare with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (medians_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("unexpected median word: row %0d col %0d rgb %0d/%0d/%0d",
                     out_data.centre_row, out_data.centre_col, out_data.red_median,
                     out_data.green_median, out_data.blue_median);
        end else begin
          want = medians_due.pop_front();
          if (out_data.centre_row !== want.centre_row ||
              out_data.centre_col !== want.centre_col ||
              out_data.red_median !== want.red_median ||
              out_data.green_median !== want.green_median ||
              out_data.blue_median !== want.blue_median) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display({"median mismatch: expected row %0d col %0d rgb %0d/%0d/%0d,",
                        " got row %0d col %0d rgb %0d/%0d/%0d"},
                       want.centre_row, want.centre_col, want.red_median,
                       want.green_median, want.blue_median,
                       out_data.centre_row, out_data.centre_col, out_data.red_median,
                       out_data.green_median, out_data.blue_median);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < 9; i++) win[i] = '0;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    col_cnt = 0;
    row_cnt = 0;
    line_width_q = CFG_W'(WIDTH_RESET);

    // width below range, extreme pixel values
    add_control(ACT_WIDTH, 0, 0, 0);
    for (i = 0; i < 3; i++) add_pixel(i == 0, 8'h00, 8'h00, 8'h00);
    for (i = 0; i < 3; i++) add_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(1'b0, 8'hFF, 8'h00, 8'h80);
    add_pixel(1'b0, 8'h00, 8'hFF, 8'h80);
    add_pixel(1'b0, 8'h80, 8'h80, 8'h00);
    add_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    add_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
    // narrow the row in the middle of row two
    add_control(ACT_WIDTH, 6, 0, 0);
    for (i = 0; i < 17; i++)
      add_pixel(i == 0, pick_chan(STYLE_FULL), pick_chan(STYLE_FULL), pick_chan(STYLE_FULL));
    add_control(ACT_WIDTH, 4, 0, 0);
    for (i = 0; i < 5; i++)
      add_pixel(1'b0, pick_chan(STYLE_EXTREME), pick_chan(STYLE_FULL), pick_chan(STYLE_NARROW));

    // width above range clamps to the full line store
    add_control(ACT_WIDTH, (1 << CFG_W) - 1, 0, 0);
    for (i = 0; i < 30; i++)
      add_pixel(i == 0, pick_chan(STYLE_FULL), pick_chan(STYLE_FULL), pick_chan(STYLE_FULL));

    add_phase(0, 0, 2, 3, 240, 1'b0);
    add_phase(88, 0, 9, 9, 240, 1'b1);
    add_phase(0, 88, 16, 16, 240, 1'b1);
    add_phase(6, 6, 5, 5, 240, 1'b0);
    add_control(ACT_PACE, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (script.size() != 0 || in_push || medians_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
